FILE: hdl/mpfq_pkg.sv
// Shared types and constants for the multilevel priority FIFO queue.
package mpfq_pkg;

   localparam int KIND_BITS   = 2;
   localparam int LEVEL_BITS  = 2;
   localparam int HANDLE_BITS = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   typedef logic [KIND_BITS-1:0]   kind_type;
   typedef logic [LEVEL_BITS-1:0]  level_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   localparam kind_type KIND_ENQ  = 2'd0;
   localparam kind_type KIND_DEQ  = 2'd1;
   localparam kind_type KIND_PEEK = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // update the level tables, start the memory access
      logic load;      // move the finished result into the output register
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;  // output register empty or emptied this cycle
   } sts_type;

endpackage

FILE: hdl/mpfq_if.sv
// Request and response channel interfaces of the multilevel priority FIFO queue.
interface mpfq_req_if;
   logic                 valid;
   logic                 ready;
   mpfq_pkg::kind_type   kind;
   mpfq_pkg::level_type  priority_level;
   mpfq_pkg::handle_type entry_handle;

   modport source (output valid, output kind, output priority_level, output entry_handle,
                   input ready);
   modport sink   (input valid, input kind, input priority_level, input entry_handle,
                   output ready);
endinterface

interface mpfq_rsp_if;
   logic                 valid;
   logic                 ready;
   mpfq_pkg::handle_type served_handle;
   mpfq_pkg::level_type  served_level;
   mpfq_pkg::status_type status;
   mpfq_pkg::count_type  total_count;
   logic                 all_empty;

   modport source (output valid, output served_handle, output served_level, output status,
                   output total_count, output all_empty, input ready);
   modport sink   (input valid, input served_handle, input served_level, input status,
                   input total_count, input all_empty, output ready);
endinterface

FILE: hdl/mpfq_ctrl.sv
// Sequencing state machine of the multilevel priority FIFO queue.
module mpfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpfq_pkg::sts_type sts,
   output mpfq_pkg::ctl_type ctl
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      ctl.load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               ctl.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_execute: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> ctl.execute)
      else $error("execute did not follow capture");

endmodule

FILE: hdl/mpfq_datapath.sv
// Level tables, handle memory and result registers of the multilevel priority FIFO queue.
module mpfq_datapath #(
   parameter int LEVELS      = 4,
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mpfq_pkg::ctl_type    ctl,
   output mpfq_pkg::sts_type    sts,
   input  mpfq_pkg::kind_type   req_kind,
   input  mpfq_pkg::level_type  req_level,
   input  mpfq_pkg::handle_type req_handle,
   mpfq_rsp_if.source           rsp_chan
);

   localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int HB     = mpfq_pkg::HANDLE_BITS;
   localparam int LB     = mpfq_pkg::LEVEL_BITS;
   localparam int CB     = mpfq_pkg::COUNT_BITS;

   // captured request
   mpfq_pkg::kind_type   kind_ff;
   mpfq_pkg::level_type  level_ff;
   mpfq_pkg::handle_type handle_ff;

   // level tables
   logic [PTR_W-1:0] head_ff  [LEVELS];
   logic [PTR_W-1:0] head_in  [LEVELS];
   logic [PTR_W-1:0] tail_ff  [LEVELS];
   logic [PTR_W-1:0] tail_in  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CNT_W-1:0] count_in [LEVELS];
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;

   // handle memory
   logic [HB-1:0]     mem [DEPTH];
   logic [HB-1:0]     rd_data_ff;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // result waiting for the memory data
   logic                 pend_hit_ff;
   logic                 pend_hit_in;
   mpfq_pkg::level_type  pend_level_ff;
   mpfq_pkg::level_type  pend_level_in;
   mpfq_pkg::status_type pend_status_ff;
   mpfq_pkg::status_type pend_status_in;
   mpfq_pkg::count_type  pend_total_ff;
   logic                 pend_empty_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   mpfq_pkg::handle_type served_handle_ff;
   mpfq_pkg::level_type  served_level_ff;
   mpfq_pkg::status_type status_ff;
   mpfq_pkg::count_type  total_count_ff;
   logic                 all_empty_ff;

   logic [LVL_W-1:0] enq_lv;
   logic [LVL_W-1:0] busy_lv;
   logic             busy_any;
   logic             enq_full;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // saturate the requested level to the last one
   always_comb begin
      if (32'(level_ff) > LEVELS - 1) begin
         enq_lv = LVL_W'(LEVELS - 1);
      end else begin
         enq_lv = LVL_W'(level_ff);
      end
   end

   // lowest-numbered non-empty level
   always_comb begin
      busy_lv  = '0;
      busy_any = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            busy_lv  = LVL_W'(i);
            busy_any = 1'b1;
         end
      end
   end

   assign enq_full = (count_ff[enq_lv] == CNT_W'(LEVEL_DEPTH));
   assign wr_addr  = ADDR_W'(32'(enq_lv) * LEVEL_DEPTH + 32'(tail_ff[enq_lv]));
   assign rd_addr  = ADDR_W'(32'(busy_lv) * LEVEL_DEPTH + 32'(head_ff[busy_lv]));

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      pend_hit_in    = 1'b0;
      pend_level_in  = '0;
      pend_status_in = mpfq_pkg::ST_OK;
      if (ctl.execute) begin
         unique case (kind_ff)
            mpfq_pkg::KIND_ENQ: begin
               pend_level_in = LB'(enq_lv);
               if (enq_full) begin
                  pend_status_in = mpfq_pkg::ST_FULL;
               end else begin
                  wr_en            = 1'b1;
                  tail_in[enq_lv]  = ptr_step(tail_ff[enq_lv]);
                  count_in[enq_lv] = count_ff[enq_lv] + 1'b1;
                  total_in         = total_ff + 1'b1;
               end
            end
            mpfq_pkg::KIND_DEQ, mpfq_pkg::KIND_PEEK: begin
               if (!busy_any) begin
                  pend_status_in = mpfq_pkg::ST_EMPTY;
               end else begin
                  rd_en         = 1'b1;
                  pend_hit_in   = 1'b1;
                  pend_level_in = LB'(busy_lv);
                  if (kind_ff == mpfq_pkg::KIND_DEQ) begin
                     head_in[busy_lv]  = ptr_step(head_ff[busy_lv]);
                     count_in[busy_lv] = count_ff[busy_lv] - 1'b1;
                     total_in          = total_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= handle_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         kind_ff   <= req_kind;
         level_ff  <= req_level;
         handle_ff <= req_handle;
      end
      if (ctl.execute) begin
         pend_hit_ff    <= pend_hit_in;
         pend_level_ff  <= pend_level_in;
         pend_status_ff <= pend_status_in;
         pend_total_ff  <= CB'(total_in);
         pend_empty_ff  <= (total_in == '0);
      end
      if (ctl.load) begin
         served_handle_ff <= pend_hit_ff ? rd_data_ff : '0;
         served_level_ff  <= pend_level_ff;
         status_ff        <= pend_status_ff;
         total_count_ff   <= pend_total_ff;
         all_empty_ff     <= pend_empty_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.served_handle = served_handle_ff;
   assign rsp_chan.served_level  = served_level_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.total_count   = total_count_ff;
   assign rsp_chan.all_empty     = all_empty_ff;

   a_total_tracks_levels: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) == !busy_any)
      else $error("total count disagrees with level counts");

   for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
      a_level_bound: assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= CNT_W'(LEVEL_DEPTH))
         else $error("level count beyond depth");
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> sts.out_free)
      else $error("result loaded over a waiting result");

   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      (ctl.execute && pend_status_in == mpfq_pkg::ST_FULL) |=> $stable(total_ff))
      else $error("dropped enqueue changed the total");

endmodule

FILE: hdl/multilevel_priority_fifo_queue.sv
// Top level of the multilevel priority FIFO queue: controller plus datapath.
//
//   channel    role    payload
//   req_chan   sink    kind, priority_level, entry_handle
//   rsp_chan   source  served_handle, served_level, status, total_count, all_empty
//
// Each transaction passes capture, execute and load steps under the controller, and
// req_chan is ready only while it is idle, so no new request is taken before the
// last result is loaded; the registered handle memory read is what needs the
// extra step. While a result waits on a stalled rsp_chan one further request is
// accepted and executed, then the controller holds in its load step with req_chan
// not ready. Reset empties every level at once (synchronous, active high); the
// handle memory is not cleared, since only written entries are read.
module multilevel_priority_fifo_queue #(
   parameter int LEVELS      = 4,
   parameter int LEVEL_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   mpfq_req_if.sink   req_chan,
   mpfq_rsp_if.source rsp_chan
);

   mpfq_pkg::ctl_type ctl;
   mpfq_pkg::sts_type sts;

   // sequence each transaction: idle, execute, fetch and load
   mpfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // hold the per-level FIFOs and build the result
   mpfq_datapath #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_kind   (req_chan.kind),
      .req_level  (req_chan.priority_level),
      .req_handle (req_chan.entry_handle),
      .rsp_chan   (rsp_chan)
   );

endmodule
